// ===== sv/fsp_pkg.sv =====
// Constants and types shared by the frame segmenting packetizer.
package fsp_pkg;

  localparam int unsigned SegmentMax = 1476;

  localparam int unsigned FrameW  = 24;
  localparam int unsigned AddrW   = 48;
  localparam int unsigned OffsW   = 32;
  localparam int unsigned SegPosW = 11;
  localparam int unsigned LenW    = 16;
  localparam int unsigned CntW    = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 48;
  localparam int unsigned StepW   = 6;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  typedef logic [StepW-1:0]   step_t;

  localparam cfg_idx_t CfgFrameBytes = 2'd0;
  localparam cfg_idx_t CfgDestAddr   = 2'd1;
  localparam cfg_idx_t CfgSrcAddr    = 2'd2;
  localparam cfg_idx_t CfgOffsetBase = 2'd3;

  localparam logic [FrameW-1:0] FrameBytesRst = 24'd6220800;
  localparam logic [AddrW-1:0]  DestAddrRst   = 48'd0;
  localparam logic [AddrW-1:0]  SrcAddrRst    = 48'd1;
  localparam logic [OffsW-1:0]  OffsetBaseRst = 32'h000F_0000;

  localparam logic [7:0] FlowData = 8'h1E;
  localparam logic [7:0] FlowSync = 8'h12;
  localparam logic [7:0] FillByte = 8'hCC;

  // Byte positions inside a 20-byte header.
  localparam logic [4:0] HdrSrc0  = 5'd6;
  localparam logic [4:0] HdrCnt   = 5'd12;
  localparam logic [4:0] HdrLenHi = 5'd13;
  localparam logic [4:0] HdrLenLo = 5'd14;
  localparam logic [4:0] HdrFlow  = 5'd15;
  localparam logic [4:0] HdrLast  = 5'd19;

  // Output sequence of one item: data header, data byte, trailer, sync packet.
  localparam step_t StepHdr0     = 6'd0;
  localparam step_t StepHdrEnd   = 6'd19;
  localparam step_t StepData     = 6'd20;
  localparam step_t StepTrail0   = 6'd21;
  localparam step_t StepTrailEnd = 6'd24;
  localparam step_t StepSync0    = 6'd25;
  localparam step_t StepLast     = 6'd44;

  typedef struct packed {
    logic [7:0]      data;
    logic            has_hdr;
    logic            seg_end;
    logic            frame_end;
    logic [LenW-1:0] len;
    logic [OffsW-1:0] offs;
    logic [CntW-1:0] cnt_hdr;
    logic [CntW-1:0] cnt_sync;
  } item_t;

endpackage

// ===== sv/frame_segmenting_packetizer_unit.sv =====
// Frame segmenting packetizer: turns pixel bytes into headed, trailed segments.
//
// Every accepted pixel byte is stamped on entry with its segment and frame
// information and held in an item register; the output byte register then
// sends its results one per cycle while out_ready_i is high. An item sends one
// data byte, plus a 20-byte segment header when it opens a segment, a 4-byte
// trailer when it ends a segment and a 20-byte sync packet at the end of a
// frame, so 1 to 45 bytes, all through the single output byte register.
// The next item is taken in the cycle its predecessor sends its last byte.
module frame_segmenting_packetizer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  fsp_pkg::cfg_idx_t            cfg_idx_i,
  input  logic [fsp_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   data_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   out_byte_o,
  output logic                         packet_end_o,
  output logic                         run_last_o
);
  import fsp_pkg::*;

  logic [FrameW-1:0]  frame_bytes_q;
  logic [AddrW-1:0]   dest_q;
  logic [AddrW-1:0]   src_q;
  logic [OffsW-1:0]   base_q;

  logic [CntW-1:0]    pkt_cnt_q, pkt_cnt_d;
  logic [FrameW-1:0]  frame_pos_q, frame_pos_d;
  logic [SegPosW-1:0] seg_pos_q, seg_pos_d;

  item_t              item_q, item_d;
  logic               item_valid_q;
  step_t              step_q, step_next;

  logic [7:0]         out_byte_q, byte_d;
  logic               pend_q, pend_d;
  logic               rlast_q;
  logic               out_valid_q;

  logic               in_acc, out_load, emit, last;
  logic [FrameW-1:0]  remaining;
  logic               is_sync;
  logic [4:0]         h;
  logic [2:0]         addr_k;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_bytes_q <= FrameBytesRst;
      dest_q        <= DestAddrRst;
      src_q         <= SrcAddrRst;
      base_q        <= OffsetBaseRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFrameBytes: frame_bytes_q <= cfg_data_i[FrameW-1:0];
        CfgDestAddr:   dest_q        <= cfg_data_i[AddrW-1:0];
        CfgSrcAddr:    src_q         <= cfg_data_i[AddrW-1:0];
        CfgOffsetBase: base_q        <= cfg_data_i[OffsW-1:0];
        default: ;
      endcase
    end
  end

  assign out_load   = !out_valid_q || out_ready_i;
  assign emit       = item_valid_q && out_load;
  assign in_ready_o = !item_valid_q || (out_load && last);
  assign in_acc     = in_valid_i && in_ready_o;

  // Entry stamping: segment and frame bookkeeping for the incoming byte.
  always_comb begin
    item_d.data      = data_byte_i;
    item_d.has_hdr   = (seg_pos_q == '0);
    item_d.frame_end = ({1'b0, frame_pos_q} + (FrameW+1)'(1)) >= {1'b0, frame_bytes_q};
    item_d.seg_end   = item_d.frame_end ||
                       (({1'b0, seg_pos_q} + (SegPosW+1)'(1)) >= (SegPosW+1)'(SegmentMax));
    remaining        = (frame_bytes_q > frame_pos_q) ? (frame_bytes_q - frame_pos_q)
                                                     : FrameW'(1);
    item_d.len       = ((remaining > FrameW'(SegmentMax)) ? LenW'(SegmentMax)
                                                          : remaining[LenW-1:0])
                       + LenW'(4);
    item_d.offs      = base_q + OffsW'(frame_pos_q);
    item_d.cnt_hdr   = pkt_cnt_q;
    item_d.cnt_sync  = pkt_cnt_q + CntW'(item_d.has_hdr);

    pkt_cnt_d   = item_d.cnt_sync + CntW'(item_d.frame_end);
    seg_pos_d   = item_d.seg_end ? '0 : seg_pos_q + SegPosW'(1);
    frame_pos_d = item_d.frame_end ? '0 : frame_pos_q + FrameW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_cnt_q   <= '0;
      frame_pos_q <= '0;
      seg_pos_q   <= '0;
    end else if (in_acc) begin
      pkt_cnt_q   <= pkt_cnt_d;
      frame_pos_q <= frame_pos_d;
      seg_pos_q   <= seg_pos_d;
    end
  end

  // Step sequencing through the output layout of one item.
  always_comb begin
    step_next = step_q + StepW'(1);
    last      = 1'b0;
    if (step_q == StepData) begin
      if (!item_q.seg_end) begin
        last = 1'b1;
      end
    end else if (step_q == StepTrailEnd) begin
      if (!item_q.frame_end) begin
        last = 1'b1;
      end
    end else if (step_q == StepLast) begin
      last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      step_q       <= StepHdr0;
    end else if (in_acc) begin
      item_valid_q <= 1'b1;
      step_q       <= item_d.has_hdr ? StepHdr0 : StepData;
    end else if (emit) begin
      if (last) begin
        item_valid_q <= 1'b0;
      end
      step_q <= step_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= item_d;
    end
  end

  // Byte selection for the current step.
  always_comb begin
    is_sync = (step_q >= StepSync0);
    h       = is_sync ? 5'(step_q - StepSync0) : step_q[4:0];
    addr_k  = 3'd0;
    byte_d  = FillByte;
    pend_d  = 1'b0;
    if (step_q == StepData) begin
      byte_d = item_q.data;
    end else if (step_q >= StepTrail0 && step_q <= StepTrailEnd) begin
      byte_d = FillByte;
      pend_d = (step_q == StepTrailEnd);
    end else if (h < HdrSrc0) begin
      addr_k = 3'(HdrSrc0 - 5'd1 - h);
      byte_d = 8'(dest_q >> {addr_k, 3'b000});
    end else if (h < HdrCnt) begin
      addr_k = 3'(HdrCnt - 5'd1 - h);
      byte_d = 8'(src_q >> {addr_k, 3'b000});
    end else if (h == HdrCnt) begin
      byte_d = is_sync ? item_q.cnt_sync : item_q.cnt_hdr;
    end else if (h == HdrLenHi) begin
      byte_d = is_sync ? 8'h00 : item_q.len[15:8];
    end else if (h == HdrLenLo) begin
      byte_d = is_sync ? 8'h00 : item_q.len[7:0];
    end else if (h == HdrFlow) begin
      byte_d = is_sync ? FlowSync : FlowData;
    end else begin
      byte_d = is_sync ? FillByte : 8'(item_q.offs >> {h[1:0], 3'b000});
      pend_d = is_sync && (h == HdrLast);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= byte_d;
      pend_q     <= pend_d;
      rlast_q    <= last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign packet_end_o = pend_q;
  assign run_last_o   = rlast_q;

`ifndef ASSERT_OFF
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q |-> step_q <= StepLast)
    else $error("Output step ran past the end of the sequence.");

  a_no_hdr_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_q && !item_q.has_hdr) |-> step_q >= StepData)
    else $error("Header bytes sent for an item that opens no segment.");

  a_end_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && packet_end_o) |-> out_byte_o == FillByte)
    else $error("Packet end flagged on a byte other than a fill byte.");

  a_sync_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && step_q == StepLast) |=> (out_valid_o && run_last_o && packet_end_o))
    else $error("Sync packet end not flagged as the item's last byte.");
`endif

endmodule
